@@ rtl/lnc_pkg.sv @@
// Shared constants, types and the sequencer state type for the longest non-increasing chain block.
package lnc_pkg;

   localparam int unsigned MAX_LEN_DEF = 1024;
   localparam int unsigned VALUE_W     = 48;
   localparam int unsigned RSP_LEN_W   = 11;
   localparam int unsigned REQ_DATA_W  = 48;
   localparam int unsigned RSP_DATA_W  = 24;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_CHECK,
      ST_WRITE,
      ST_REPLY
   } state_type;

   typedef struct packed {
      logic [RSP_LEN_W-1:0] chain_len;
      logic [RSP_LEN_W-1:0] best_len;
      logic                 saturated;
      logic                 last_res;
   } rsp_word_type;

endpackage

@@ rtl/lnc_tail_ram.sv @@
// Single-port tail memory with registered read data.
module lnc_tail_ram #(
   parameter int unsigned MAX_LEN = lnc_pkg::MAX_LEN_DEF,
   localparam int unsigned ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
   input  logic                                clock,
   input  logic                                mem_en,
   input  logic                                mem_we,
   input  logic [ADDR_W-1:0]                   mem_addr,
   input  logic signed [lnc_pkg::VALUE_W-1:0]  mem_wdata,
   output logic signed [lnc_pkg::VALUE_W-1:0]  mem_rdata
);
   import lnc_pkg::*;

   logic signed [VALUE_W-1:0] tail_ff [MAX_LEN];
   logic signed [VALUE_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_en) begin
         if (mem_we) begin
            tail_ff[mem_addr] <= mem_wdata;
         end else begin
            rdata_ff <= tail_ff[mem_addr];
         end
      end
   end

   assign mem_rdata = rdata_ff;

endmodule

@@ rtl/lnc_seq.sv @@
// Search sequencer: binary search over the stored tails with one shared compare, then update.
module lnc_seq #(
   parameter int unsigned MAX_LEN = lnc_pkg::MAX_LEN_DEF,
   localparam int unsigned ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1,
   localparam int unsigned LEN_W  = $clog2(MAX_LEN + 1)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [lnc_pkg::VALUE_W-1:0]  req_value,
   input  logic                                req_last,
   output logic                                mem_en,
   output logic                                mem_we,
   output logic [ADDR_W-1:0]                   mem_addr,
   output logic signed [lnc_pkg::VALUE_W-1:0]  mem_wdata,
   input  logic signed [lnc_pkg::VALUE_W-1:0]  mem_rdata,
   output logic                                res_valid,
   input  logic                                res_ready,
   output lnc_pkg::rsp_word_type               res_word
);
   import lnc_pkg::*;

   state_type                 state_ff, state_in;
   logic [LEN_W-1:0]          used_ff, used_in;
   logic [LEN_W-1:0]          lo_ff, lo_in;
   logic [LEN_W-1:0]          hi_ff, hi_in;
   logic [LEN_W-1:0]          mid_ff, mid_in;
   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic                      last_ff, last_in;
   rsp_word_type              res_ff, res_in;

   logic [LEN_W:0]            mid_sum;
   logic [LEN_W-1:0]          mid;
   logic                      lo_lt_hi;
   logic                      ext_sat;
   logic [LEN_W-1:0]          len_new;
   logic [LEN_W-1:0]          used_new;

   assign mid_sum  = {1'b0, lo_ff} + {1'b0, hi_ff} + {{LEN_W{1'b0}}, 1'b1};
   assign mid      = mid_sum[LEN_W:1];
   assign lo_lt_hi = lo_ff < hi_ff;
   assign ext_sat  = lo_ff == LEN_W'(MAX_LEN);
   assign len_new  = ext_sat ? LEN_W'(MAX_LEN) : lo_ff + {{(LEN_W-1){1'b0}}, 1'b1};
   assign used_new = (!ext_sat && (len_new > used_ff)) ? len_new : used_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            state_in = lo_lt_hi ? ST_CHECK : ST_WRITE;
         end
         ST_CHECK: begin
            state_in = ST_SEARCH;
         end
         ST_WRITE: begin
            state_in = ST_REPLY;
         end
         ST_REPLY: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      res_valid = 1'b0;
      mem_en    = 1'b0;
      mem_we    = 1'b0;
      mem_addr  = ADDR_W'(lo_ff);
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_SEARCH: begin
            mem_en   = lo_lt_hi;
            mem_addr = ADDR_W'(mid - {{(LEN_W-1){1'b0}}, 1'b1});
         end
         ST_WRITE: begin
            mem_en = !ext_sat;
            mem_we = !ext_sat;
         end
         ST_REPLY: begin
            res_valid = 1'b1;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      used_in  = used_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      mid_in   = mid_ff;
      value_in = value_ff;
      last_in  = last_ff;
      res_in   = res_ff;
      case (state_ff)
         ST_IDLE: begin
            value_in = req_value;
            last_in  = req_last;
            lo_in    = '0;
            hi_in    = used_ff;
         end
         ST_SEARCH: begin
            mid_in = mid;
         end
         ST_CHECK: begin
            if (mem_rdata >= value_ff) begin
               lo_in = mid_ff;
            end else begin
               hi_in = mid_ff - {{(LEN_W-1){1'b0}}, 1'b1};
            end
         end
         ST_WRITE: begin
            res_in.chain_len = RSP_LEN_W'(len_new);
            res_in.best_len  = RSP_LEN_W'(used_new);
            res_in.saturated = ext_sat;
            res_in.last_res  = last_ff;
            used_in          = last_ff ? '0 : used_new;
         end
         default: begin
            used_in = used_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         used_ff  <= '0;
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      mid_ff   <= mid_in;
      value_ff <= value_in;
      last_ff  <= last_in;
      res_ff   <= res_in;
   end

   assign mem_wdata = value_ff;
   assign res_word  = res_ff;

   a_used_bounded: assert property (@(posedge clock) disable iff (reset)
      used_ff <= LEN_W'(MAX_LEN))
      else $error("tail count exceeds the table depth");

   a_window_ordered: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH || state_ff == ST_CHECK) |-> (lo_ff <= hi_ff))
      else $error("search window inverted");

   a_window_in_table: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH || state_ff == ST_CHECK) |-> (hi_ff <= used_ff))
      else $error("search window reaches past the stored tails");

   a_grow_covers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE && !ext_sat && !last_ff) |=> (used_ff > lo_ff))
      else $error("tail count did not cover the new chain length");

endmodule

@@ rtl/longest_nonincreasing_chain.sv @@
// Top level of the streaming longest non-increasing chain block.
//
//   Channel  Direction  Handshake            Payload
//   req      in         req_tvalid/tready    tdata: value[47:0]; tlast: last
//   rsp      out        rsp_tvalid/tready    tdata: chain_len, best_len, saturated; tlast
//
// Each word runs a binary search over the stored tails, then the write state and the reply state.
// Each step of the binary search is one memory read and one compare of the read data.
// Reset clears the sequencer and the tail count; the tail memory needs no clearing.
// A finished result sits in the output register, so the next word is taken while it waits.
module longest_nonincreasing_chain #(
   parameter int unsigned MAX_LEN = lnc_pkg::MAX_LEN_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [lnc_pkg::REQ_DATA_W-1:0]       req_tdata,  // value[47:0]
   input  logic                                 req_tlast,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [lnc_pkg::RSP_DATA_W-1:0]       rsp_tdata,  // chain_len, best_len, saturated, zero
   output logic                                 rsp_tlast
);
   import lnc_pkg::*;

   localparam int unsigned ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

   logic                      mem_en;
   logic                      mem_we;
   logic [ADDR_W-1:0]         mem_addr;
   logic signed [VALUE_W-1:0] mem_wdata;
   logic signed [VALUE_W-1:0] mem_rdata;
   logic                      res_valid;
   logic                      res_ready;
   rsp_word_type              res_word;

   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_word_type              rsp_word_ff, rsp_word_in;

   lnc_seq #(
      .MAX_LEN (MAX_LEN)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_value ($signed(req_tdata[VALUE_W-1:0])),
      .req_last  (req_tlast),
      .mem_en    (mem_en),
      .mem_we    (mem_we),
      .mem_addr  (mem_addr),
      .mem_wdata (mem_wdata),
      .mem_rdata (mem_rdata),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res_word  (res_word)
   );

   lnc_tail_ram #(
      .MAX_LEN (MAX_LEN)
   ) u_tail_ram (
      .clock     (clock),
      .mem_en    (mem_en),
      .mem_we    (mem_we),
      .mem_addr  (mem_addr),
      .mem_wdata (mem_wdata),
      .mem_rdata (mem_rdata)
   );

   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = res_word;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_word_ff.saturated, rsp_word_ff.best_len,
                        rsp_word_ff.chain_len};
   assign rsp_tlast  = rsp_word_ff.last_res;

endmodule
